// ===== sv/c2e_pkg.sv =====
// shared types, widths and tables for the calendar to epoch seconds converter
package c2e_pkg;

    localparam int YEAR_W = 11;
    localparam int MON_W  = 4;
    localparam int MDAY_W = 5;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int EPOCH_W = 36;
    localparam int YDAY_W  = 9;
    localparam int WDAY_W  = 3;

    // day count since the epoch and time of day in seconds
    localparam int DAY_W  = 20;
    localparam int TOD_W  = 17;
    localparam int PROD_W = DAY_W + TOD_W;

    localparam logic [YEAR_W-1:0]  YEAR_EPOCH   = 11'd70;
    localparam logic [YEAR_W-1:0]  YEAR_CENTURY = 11'd201;
    localparam logic [11:0]        YEAR_BASE    = 12'd1900;
    localparam logic [12:0]        RECIP_100    = 13'd5243;
    localparam int                 RECIP_SHIFT  = 19;
    localparam logic [TOD_W-1:0]   SEC_PER_DAY  = 17'd86400;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX    = 36'h7_FFFF_FFFF;
    localparam logic [MON_W-1:0]   MON_FEB      = 4'd1;

    // payload handed from the day count stages to the seconds stages
    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [TOD_W-1:0]  tod;
        logic [YDAY_W-1:0] yday;
        logic              early;
    } t_day_beat;

    // days before each month in a common year, months past december read as december
    function automatic logic [YDAY_W-1:0] days_before_month(input logic [MON_W-1:0] mon);
        logic [YDAY_W-1:0] d;
        case (mon)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            default: d = 9'd334;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/c2e_tail.sv =====
// seconds stages: day times seconds per day, time of day add, saturation, weekday
module c2e_tail (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    output logic                                o_rdy,
    input  c2e_pkg::t_day_beat                  i_beat,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [c2e_pkg::EPOCH_W-1:0]  o_epoch_seconds,
    output logic        [c2e_pkg::YDAY_W-1:0]   o_day_of_year,
    output logic        [c2e_pkg::WDAY_W-1:0]   o_weekday,
    output logic                                o_before_epoch
);
    import c2e_pkg::*;

    logic r_v4, r_v5;
    logic adv4, adv5;

    logic [PROD_W-1:0] r_prod;
    logic [TOD_W-1:0]  r_tod;
    logic [5:0]        r_wsum;
    logic [YDAY_W-1:0] r_yday4;
    logic              r_before4;

    logic [PROD_W-1:0] n_prod;
    logic [DAY_W:0]    n_wx;
    logic [5:0]        n_wsum;

    logic [PROD_W:0]      n_secs;
    logic [EPOCH_W-1:0]   n_epoch;
    logic [3:0]           n_w2;
    logic [WDAY_W-1:0]    n_wday;

    logic [EPOCH_W-1:0] r_epoch;
    logic [YDAY_W-1:0]  r_yday5;
    logic [WDAY_W-1:0]  r_wday;
    logic               r_before5;

    assign adv5  = !r_v5 || i_ready;
    assign adv4  = !r_v4 || adv5;
    assign o_rdy = adv4;

    // octal digit sum keeps the value mod 7 since 8 is 1 mod 7
    always_comb begin
        n_prod = PROD_W'(i_beat.day) * PROD_W'(SEC_PER_DAY);
        n_wx   = (DAY_W+1)'(i_beat.day) + (DAY_W+1)'(4);
        n_wsum = '0;
        for (int k = 0; k < (DAY_W + 3) / 3; k++) begin
            n_wsum = n_wsum + 6'(n_wx[k*3 +: 3]);
        end
    end

    always_comb begin
        n_secs = (PROD_W+1)'(r_prod) + (PROD_W+1)'(r_tod);
        if (r_before4) begin
            n_epoch = '1;
        end else if (n_secs > (PROD_W+1)'(EPOCH_MAX)) begin
            n_epoch = EPOCH_MAX;
        end else begin
            n_epoch = n_secs[EPOCH_W-1:0];
        end
        n_w2 = 4'(r_wsum[5:3]) + 4'(r_wsum[2:0]);
        if (r_before4) begin
            n_wday = '0;
        end else if (n_w2 >= 4'd7) begin
            n_wday = WDAY_W'(n_w2 - 4'd7);
        end else begin
            n_wday = WDAY_W'(n_w2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (adv4) begin
                r_v4 <= i_vld;
            end
            if (adv5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4 && i_vld) begin
            r_prod    <= n_prod;
            r_tod     <= i_beat.tod;
            r_wsum    <= n_wsum;
            r_yday4   <= i_beat.yday;
            r_before4 <= i_beat.early;
        end
        if (adv5 && r_v4) begin
            r_epoch   <= n_epoch;
            r_yday5   <= r_before4 ? '0 : r_yday4;
            r_wday    <= n_wday;
            r_before5 <= r_before4;
        end
    end

    assign o_valid         = r_v5;
    assign o_epoch_seconds = $signed(r_epoch);
    assign o_day_of_year   = r_yday5;
    assign o_weekday       = r_wday;
    assign o_before_epoch  = r_before5;

endmodule

// ===== sv/calendar_to_epoch_seconds.sv =====
// top level: utc calendar date and time to seconds since 1970-01-01
//
// Converts one broken-down UTC date and time per beat into Unix seconds, the
// zero-based day of the year and the weekday (0 Sunday .. 6 Saturday). Years
// are counted from 1900; a year before 1970 gives epoch seconds of -1, day of
// year and weekday of 0 and raises before_epoch. Leap years follow the full
// Gregorian rule (2100, 2200, 2300 are common, 2400 is leap). A day number past
// the end of its month runs on into the next month, a month above 11 reads as
// December, day 0 reads as day 1, and oversized hour, minute or second values
// are added in without carry. Epoch seconds saturate at 2^35-1. The block is a
// five stage pipeline: one beat can enter every cycle while the output side is
// not stalled, and each result is held at the output until it is taken.
// The stage depth is set by the reciprocal multiplies for the century and
// leap tests and by the 20 x 17 bit day times 86400 multiply. Each stage holds
// a valid bit and moves on whenever the stage after it is empty or moving, so
// bubbles close up and input is taken while a finished result waits.
module calendar_to_epoch_seconds (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [10:0]         i_year_since_1900,
    input  logic [3:0]          i_month,
    input  logic [4:0]          i_day_of_month,
    input  logic [4:0]          i_hour,
    input  logic [5:0]          i_minute,
    input  logic [5:0]          i_second,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [35:0]  o_epoch_seconds,
    output logic [8:0]          o_day_of_year,
    output logic [2:0]          o_weekday,
    output logic                o_before_epoch
);
    import c2e_pkg::*;

    // stage valid bits and advance enables
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;
    logic tail_rdy;

    // stage 1: clamps, month table, reciprocal multiplies, time of day
    logic [YEAR_W-1:0] n_years;
    logic [YEAR_W-1:0] n_cent;
    logic [11:0]       n_year_full;
    logic [MDAY_W-1:0] n_mday;
    logic [YDAY_W-1:0] n_ybase;
    logic [23:0]       n_cprod;
    logic [24:0]       n_yprod;
    logic [TOD_W-1:0]  n_tod;

    logic [YEAR_W-1:0] r_years;
    logic [11:0]       r_year_full;
    logic [23:0]       r_cprod;
    logic [24:0]       r_yprod;
    logic              r_cent_ge;
    logic              r_before1;
    logic              r_late_mon;
    logic [YDAY_W-1:0] r_ybase;
    logic [TOD_W-1:0]  r_tod1;

    // stage 2: leap test, century correction, days to start of year
    logic [4:0]        cq;
    logic [5:0]        yq;
    logic [1:0]        cq_low;
    logic              leap;
    logic [4:0]        n_corr;
    logic [DAY_W-1:0]  n_dbase;
    logic [YDAY_W-1:0] n_yday;

    logic [DAY_W-1:0]  r_dbase;
    logic [YDAY_W-1:0] r_yday2;
    logic [TOD_W-1:0]  r_tod2;
    logic              r_before2;

    // stage 3: day number since the epoch
    t_day_beat r_beat3;

    assign adv3    = !r_v3 || tail_rdy;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    always_comb begin
        n_years     = i_year_since_1900 - YEAR_EPOCH;
        n_cent      = i_year_since_1900 - YEAR_CENTURY;
        n_year_full = 12'(i_year_since_1900) + YEAR_BASE;
        // day zero reads as day one
        n_mday      = (i_day_of_month == '0) ? MDAY_W'(1) : i_day_of_month;
        n_ybase     = days_before_month(i_month) + YDAY_W'(n_mday) - YDAY_W'(1);
        // floor(x / 100) as x * 5243 >> 19, exact for these ranges
        n_cprod     = 24'(n_cent) * 24'(RECIP_100);
        n_yprod     = 25'(n_year_full) * 25'(RECIP_100);
        n_tod       = TOD_W'(i_hour) * TOD_W'(3600) + TOD_W'(i_minute) * TOD_W'(60)
                    + TOD_W'(i_second);
    end

    always_comb begin
        cq     = r_cprod[RECIP_SHIFT +: 5];
        yq     = r_yprod[RECIP_SHIFT +: 6];
        // year % 4 follows the low bits since 1900 is a multiple of 4
        leap   = (r_year_full[1:0] == 2'b00)
              && ((r_year_full != 12'(yq) * 12'd100) || (yq[1:0] == 2'b00));
        // skipped leap days: three per 400 years plus one per extra century
        cq_low = (cq[1:0] == 2'd3) ? 2'd2 : cq[1:0];
        if (r_cent_ge) begin
            n_corr = 5'(cq[4:2]) * 5'd3 + 5'd1 + 5'(cq_low);
        end else begin
            n_corr = '0;
        end
        n_dbase = DAY_W'(r_years) * DAY_W'(365)
                + DAY_W'((YEAR_W+1)'(r_years) + (YEAR_W+1)'(1) >> 2)
                - DAY_W'(n_corr);
        n_yday  = r_ybase + YDAY_W'(r_late_mon && leap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_years     <= n_years;
            r_year_full <= n_year_full;
            r_cprod     <= n_cprod;
            r_yprod     <= n_yprod;
            r_cent_ge   <= (i_year_since_1900 >= YEAR_CENTURY);
            r_before1   <= (i_year_since_1900 < YEAR_EPOCH);
            r_late_mon  <= (i_month > MON_FEB);
            r_ybase     <= n_ybase;
            r_tod1      <= n_tod;
        end
        if (adv2 && r_v1) begin
            r_dbase   <= n_dbase;
            r_yday2   <= n_yday;
            r_tod2    <= r_tod1;
            r_before2 <= r_before1;
        end
        if (adv3 && r_v2) begin
            r_beat3.day   <= r_dbase + DAY_W'(r_yday2);
            r_beat3.tod   <= r_tod2;
            r_beat3.yday  <= r_yday2;
            r_beat3.early <= r_before2;
        end
    end

    // stages 4 and 5: seconds, saturation, weekday and the output register
    c2e_tail u_tail (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (r_v3),
        .o_rdy           (tail_rdy),
        .i_beat          (r_beat3),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_epoch_seconds (o_epoch_seconds),
        .o_day_of_year   (o_day_of_year),
        .o_weekday       (o_weekday),
        .o_before_epoch  (o_before_epoch)
    );

endmodule

// ===== tb/tb_calendar_to_epoch_seconds.sv =====
// self-checking testbench for the calendar to epoch seconds converter
module tb_calendar_to_epoch_seconds;
    import c2e_pkg::*;

    // one broken-down utc date and time, as driven on the input ports
    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [MDAY_W-1:0] mday;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } t_calendar_date;

    // one converted result, epoch kept as raw bits and shown signed
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [YDAY_W-1:0]  yday;
        logic [WDAY_W-1:0]  wday;
        logic               early;
    } t_epoch_result;

    // a row of the directed table: typed rows carry their own answer
    typedef struct packed {
        t_calendar_date date;
        logic           typed;
        t_epoch_result  result;
    } t_date_row;

    localparam int N_DIRECTED   = 24;
    localparam int N_RANDOM     = 850;
    localparam int MAX_IDLE     = 15;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SAT_YEAR     = 1160;

    // answers that can be read off directly
    localparam t_epoch_result PRE_EPOCH  = '{36'hF_FFFF_FFFF, 9'd0, 3'd0, 1'b1};
    localparam t_epoch_result AT_EPOCH   = '{36'd0, 9'd0, 3'd4, 1'b0};
    localparam t_epoch_result EPOCH_P1   = '{36'd1, 9'd0, 3'd4, 1'b0};
    localparam t_epoch_result DAY1_END   = '{36'd86399, 9'd0, 3'd4, 1'b0};
    localparam t_epoch_result DAY2_START = '{36'd86400, 9'd1, 3'd5, 1'b0};
    localparam t_epoch_result UNTYPED    = '0;

    localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    t_date_row directed_rows [N_DIRECTED] = '{
        // years before 1970, including oversized fields
        '{'{11'd0,    4'd0,  5'd1,  5'd0,  6'd0,  6'd0},  1'b1, PRE_EPOCH},
        '{'{11'd69,   4'd11, 5'd31, 5'd23, 6'd59, 6'd60}, 1'b1, PRE_EPOCH},
        '{'{11'd69,   4'd15, 5'd0,  5'd31, 6'd63, 6'd63}, 1'b1, PRE_EPOCH},
        // around the epoch itself
        '{'{11'd70,   4'd0,  5'd1,  5'd0,  6'd0,  6'd0},  1'b1, AT_EPOCH},
        '{'{11'd70,   4'd0,  5'd1,  5'd0,  6'd0,  6'd1},  1'b1, EPOCH_P1},
        '{'{11'd70,   4'd0,  5'd1,  5'd23, 6'd59, 6'd59}, 1'b1, DAY1_END},
        '{'{11'd70,   4'd0,  5'd2,  5'd0,  6'd0,  6'd0},  1'b1, DAY2_START},
        // day zero reads as day one, then the last second of 1970
        '{'{11'd70,   4'd0,  5'd0,  5'd0,  6'd0,  6'd0},  1'b1, AT_EPOCH},
        '{'{11'd70,   4'd11, 5'd31, 5'd23, 6'd59, 6'd59}, 1'b0, UNTYPED},
        // leap years and century rules
        '{'{11'd72,   4'd1,  5'd29, 5'd12, 6'd0,  6'd0},  1'b0, UNTYPED},
        '{'{11'd72,   4'd2,  5'd1,  5'd0,  6'd0,  6'd0},  1'b0, UNTYPED},
        '{'{11'd100,  4'd11, 5'd31, 5'd23, 6'd59, 6'd60}, 1'b0, UNTYPED},
        '{'{11'd100,  4'd1,  5'd31, 5'd0,  6'd0,  6'd0},  1'b0, UNTYPED},
        '{'{11'd200,  4'd2,  5'd1,  5'd0,  6'd0,  6'd0},  1'b0, UNTYPED},
        '{'{11'd201,  4'd0,  5'd1,  5'd0,  6'd0,  6'd0},  1'b0, UNTYPED},
        '{'{11'd300,  4'd11, 5'd31, 5'd0,  6'd0,  6'd0},  1'b0, UNTYPED},
        '{'{11'd400,  4'd2,  5'd1,  5'd0,  6'd0,  6'd0},  1'b0, UNTYPED},
        '{'{11'd500,  4'd2,  5'd1,  5'd0,  6'd0,  6'd0},  1'b0, UNTYPED},
        // month above december and oversized time of day
        '{'{11'd123,  4'd12, 5'd15, 5'd6,  6'd30, 6'd0},  1'b0, UNTYPED},
        '{'{11'd123,  4'd15, 5'd1,  5'd0,  6'd0,  6'd0},  1'b0, UNTYPED},
        '{'{11'd123,  4'd5,  5'd15, 5'd31, 6'd63, 6'd63}, 1'b0, UNTYPED},
        // top of the range and saturation
        '{'{11'd1099, 4'd11, 5'd31, 5'd23, 6'd59, 6'd60}, 1'b0, UNTYPED},
        '{'{11'd1160, 4'd0,  5'd1,  5'd0,  6'd0,  6'd0},  1'b0, UNTYPED},
        '{'{11'd2047, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63}, 1'b0, UNTYPED}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [10:0]         i_year_since_1900 = '0;
    logic [3:0]          i_month = '0;
    logic [4:0]          i_day_of_month = '0;
    logic [4:0]          i_hour = '0;
    logic [5:0]          i_minute = '0;
    logic [5:0]          i_second = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic signed [35:0]  o_epoch_seconds;
    logic [8:0]          o_day_of_year;
    logic [2:0]          o_weekday;
    logic                o_before_epoch;

    t_epoch_result expected_epoch_q [$];
    int            mismatch_count = 0;
    int            dates_offered = 0;
    int            results_taken = 0;
    bit            sender_quiet = 1'b0;
    bit            receiver_quiet = 1'b0;
    longint        cycle_count = 0;

    calendar_to_epoch_seconds i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_year_since_1900 (i_year_since_1900),
        .i_month           (i_month),
        .i_day_of_month    (i_day_of_month),
        .i_hour            (i_hour),
        .i_minute          (i_minute),
        .i_second          (i_second),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_epoch_seconds   (o_epoch_seconds),
        .o_day_of_year     (o_day_of_year),
        .o_weekday         (o_weekday),
        .o_before_epoch    (o_before_epoch)
    );

    // 20 time unit clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // expected conversion of one date: day count with the 4-year leap count,
    // century correction from 2101 on, then seconds with saturation
    function automatic t_epoch_result calc_epoch_result(input t_calendar_date d);
        longint yr, mon, mday, years, day, yday, secs, c, full_year;
        t_epoch_result r;
        yr   = longint'(d.year);
        mon  = longint'(d.month);
        mday = longint'(d.mday);
        // month above december reads as december, day zero as day one
        if (mon > 11) mon = 11;
        if (mday < 1) mday = 1;
        if (yr < 70) begin
            r = PRE_EPOCH;
            return r;
        end
        years = yr - 70;
        day   = years * 365 + (years + 1) / 4;
        c = years - 131;
        if (c >= 0) begin
            c = c / 100;
            day -= (c / 4) * 3 + 1;
            c = c % 4;
            if (c == 3) c = 2;
            day -= c;
        end
        yday = MONTH_START[mon] + mday - 1;
        full_year = yr + 1900;
        if (mon > 1 && (full_year % 4 == 0) &&
            ((full_year % 100 != 0) || (full_year % 400 == 0))) begin
            yday += 1;
        end
        day += yday;
        // time of day fields go in as they are, no carry
        secs = ((day * 24 + longint'(d.hour)) * 60 + longint'(d.minute)) * 60
             + longint'(d.second);
        if (secs > longint'(EPOCH_MAX)) secs = longint'(EPOCH_MAX);
        r.epoch = secs[EPOCH_W-1:0];
        r.yday  = yday[YDAY_W-1:0];
        r.wday  = WDAY_W'((day + 4) % 7);
        r.early = 1'b0;
        return r;
    endfunction

    // offer one date beat after a random gap, hold it until taken, and
    // record its expected result at the accepting edge
    task automatic offer_date(input t_calendar_date d, input logic typed,
                              input t_epoch_result typed_res);
        int gap;
        if (dates_offered % 50 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_year_since_1900 <= d.year;
        i_month           <= d.month;
        i_day_of_month    <= d.mday;
        i_hour            <= d.hour;
        i_minute          <= d.minute;
        i_second          <= d.second;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_epoch_q.push_back(typed ? typed_res : calc_epoch_result(d));
        dates_offered++;
        @(negedge i_clk);
    endtask

    // cycle watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("calendar_to_epoch_seconds test failed");
        $finish;
    end

    // result side: random stalls, one long hold-off so the pipe backs up,
    // every accepted beat compared with the oldest expectation
    initial begin
        int stall;
        t_epoch_result want;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (results_taken % 40 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
            if (results_taken == HOLD_AT) begin
                stall = HOLD_CYCLES;
            end else begin
                stall = receiver_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            results_taken++;
            if (expected_epoch_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, epoch %0d", $time,
                         o_epoch_seconds);
                mismatch_count++;
            end else begin
                want = expected_epoch_q.pop_front();
                if (o_epoch_seconds !== $signed(want.epoch)) begin
                    $display("%0t: epoch_seconds expected %0d actual %0d", $time,
                             $signed(want.epoch), o_epoch_seconds);
                    mismatch_count++;
                end
                if (o_day_of_year !== want.yday) begin
                    $display("%0t: day_of_year expected %0d actual %0d", $time,
                             want.yday, o_day_of_year);
                    mismatch_count++;
                end
                if (o_weekday !== want.wday) begin
                    $display("%0t: weekday expected %0d actual %0d", $time,
                             want.wday, o_weekday);
                    mismatch_count++;
                end
                if (o_before_epoch !== want.early) begin
                    $display("%0t: before_epoch expected %0d actual %0d", $time,
                             want.early, o_before_epoch);
                    mismatch_count++;
                end
            end
            @(negedge i_clk);
        end
    end

    // stimulus: reset, directed table, then random dates
    initial begin
        t_calendar_date d;
        int sel;
        // synchronous reset held low from the start, released on a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            offer_date(directed_rows[i].date, directed_rows[i].typed,
                       directed_rows[i].result);
        end

        // random dates: mostly in range, some pre-epoch, some past 2999, some around
        // century years or the saturation year, fields now and then out of range
        for (int i = 0; i < N_RANDOM; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                d.year = YEAR_W'($urandom_range(70, 1099));
            end else if (sel < 78) begin
                d.year = YEAR_W'($urandom_range(0, 69));
            end else if (sel < 88) begin
                d.year = YEAR_W'(100 * $urandom_range(2, 10) + $urandom_range(0, 2) - 1);
            end else if (sel < 94) begin
                d.year = YEAR_W'($urandom_range(SAT_YEAR - 10, SAT_YEAR + 10));
            end else begin
                d.year = YEAR_W'($urandom_range(1100, 2047));
            end
            d.month  = MON_W'(($urandom_range(0, 9) == 0)
                     ? $urandom_range(12, 15) : $urandom_range(0, 11));
            d.mday   = MDAY_W'(($urandom_range(0, 19) == 0)
                     ? 0 : $urandom_range(1, 31));
            d.hour   = HOUR_W'(($urandom_range(0, 9) == 0)
                     ? $urandom_range(24, 31) : $urandom_range(0, 23));
            d.minute = MIN_W'(($urandom_range(0, 9) == 0)
                     ? $urandom_range(60, 63) : $urandom_range(0, 59));
            d.second = SEC_W'(($urandom_range(0, 9) == 0)
                     ? $urandom_range(61, 63) : $urandom_range(0, 60));
            offer_date(d, 1'b0, UNTYPED);
        end
        i_valid <= 1'b0;

        // drain: every expected beat back, then an idle wait so stray beats show up
        while (expected_epoch_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_epoch_q.size() == 0) begin
            $display("calendar_to_epoch_seconds test passed");
        end else begin
            $display("calendar_to_epoch_seconds test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/c2e_pkg.sv
sv/c2e_tail.sv
sv/calendar_to_epoch_seconds.sv
tb/tb_calendar_to_epoch_seconds.sv
